>>> src/at_response_line_classifier_defines.svh
// Assertion helpers used by the checker file.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AT_RLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define AT_RLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/at_rlc_pkg.sv
package at_rlc_pkg;

  localparam int LINE_CAP = 62;
  localparam int ADDR_W   = $clog2(LINE_CAP);
  localparam int CNT_W    = $clog2(LINE_CAP + 1);

  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] SPACE_MAX = 8'd32;

  localparam logic [2:0] CLS_OK      = 3'd0;
  localparam logic [2:0] CLS_ERROR   = 3'd1;
  localparam logic [2:0] CLS_HTTP    = 3'd2;
  localparam logic [2:0] CLS_TEXT    = 3'd3;
  localparam logic [2:0] CLS_IGNORED = 3'd4;

  localparam int OK_LEN   = 2;
  localparam int ERR_LEN  = 5;
  localparam int ACT_LEN  = 12;
  localparam int AT_LEN   = 2;
  localparam int HTTP_LEN = 5;

  localparam logic [7:0] PFX_OK [OK_LEN] = '{8'h4F, 8'h4B};
  localparam logic [7:0] PFX_ERR [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
  localparam logic [7:0] PFX_ACT [ACT_LEN] = '{8'h2B, 8'h48, 8'h54, 8'h54, 8'h50, 8'h41,
                                               8'h43, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h3A};
  localparam logic [7:0] PFX_AT [AT_LEN] = '{8'h41, 8'h54};
  localparam logic [7:0] PFX_HTTP [HTTP_LEN] = '{8'h2B, 8'h48, 8'h54, 8'h54, 8'h50};

  typedef struct packed {
    logic store;      // accept one reply byte into the line
    logic begin_cmd;  // new command: drop capture
    logic classify;   // act on the finished line
    logic rd;         // read line store at ptr
    logic ld_byte;    // load read byte into output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic emit;       // line class carries payload bytes
    logic out_free;
    logic at_end;     // ptr is on the final stored byte
  } dp_stat_t;

endpackage

>>> src/at_response_line_classifier.sv
// Channel  Dir  Handshake           Request fields
// in       in   in_valid/in_stall   command, rx_byte
// out      out  out_valid/out_stall line_class, payload_byte, has_byte, last
//
// A reply byte or a begin command is taken while the block is idle.
// A CR leads to a classify step, then a line store read and an output load
// per payload byte; a line with no payload gives one result.
// in_stall stays high from the CR until the last result is loaded.
// out_stall holds the output register and pauses the byte loop.
// rst is synchronous; it empties the line and clears the capture flag.
module at_response_line_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] line_class,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic       last
);

  at_rlc_pkg::dp_cmd_t  cmd;
  at_rlc_pkg::dp_stat_t stat;

  at_rlc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .command (command),
    .stat    (stat),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  at_rlc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .line_class  (line_class),
    .payload_byte(payload_byte),
    .has_byte    (has_byte),
    .last        (last)
  );

endmodule

>>> src/at_rlc_ram.sv
module at_rlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/at_rlc_dp.sv
module at_rlc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  at_rlc_pkg::dp_cmd_t cmd,
  output at_rlc_pkg::dp_stat_t stat,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          line_class,
  output logic [7:0]          payload_byte,
  output logic                has_byte,
  output logic                last
);

  localparam int CW = at_rlc_pkg::CNT_W;

  logic [CW-1:0] length;
  logic [CW-1:0] lead;
  logic          in_lead;
  logic          f_ok, f_err, f_act, f_at, f_http;
  logic [CW-1:0] s2;
  logic          run2;
  logic          captured;
  logic [CW-1:0] ptr;
  logic [2:0]    cls_reg;
  logic [7:0]    rdata;

  logic          we;
  logic          is_space;
  logic          lead_byte;
  logic [CW-1:0] j;
  logic [CW-1:0] rest;
  logic          m_ok, m_err, m_act, m_at, m_http;
  logic [CW-1:0] start_h;
  logic          http_empty;
  logic [2:0]    cls;
  logic [CW-1:0] start;
  logic          emit;
  logic          cap_next;
  logic          out_free;

  assign we        = cmd.store && (length < CW'(at_rlc_pkg::LINE_CAP));
  assign is_space  = rx_byte <= at_rlc_pkg::SPACE_MAX;
  assign lead_byte = in_lead && is_space;
  assign j         = length - lead;
  assign rest      = length - lead;

  assign m_ok   = f_ok   && (rest >= CW'(at_rlc_pkg::OK_LEN));
  assign m_err  = f_err  && (rest >= CW'(at_rlc_pkg::ERR_LEN));
  assign m_act  = f_act  && (rest >= CW'(at_rlc_pkg::ACT_LEN));
  assign m_at   = f_at   && (rest >= CW'(at_rlc_pkg::AT_LEN));
  assign m_http = f_http && (rest >= CW'(at_rlc_pkg::HTTP_LEN));

  assign start_h    = lead + CW'(at_rlc_pkg::ACT_LEN) + s2;
  assign http_empty = start_h >= length;

  always_comb begin
    cls      = at_rlc_pkg::CLS_IGNORED;
    start    = lead;
    emit     = 1'b0;
    cap_next = captured;
    if (m_ok) begin
      cls = at_rlc_pkg::CLS_OK;
    end else if (m_err) begin
      cls = at_rlc_pkg::CLS_ERROR;
    end else if (m_act) begin
      cls      = at_rlc_pkg::CLS_HTTP;
      start    = start_h;
      emit     = !http_empty;
      cap_next = !http_empty;
    end else if (!captured && (length > lead) && !m_at && !m_http) begin
      cls      = at_rlc_pkg::CLS_TEXT;
      emit     = 1'b1;
      cap_next = 1'b1;
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign stat.is_cr    = rx_byte == at_rlc_pkg::CODE_CR;
  assign stat.emit     = emit;
  assign stat.out_free = out_free;
  assign stat.at_end   = (ptr + CW'(1)) == length;

  at_rlc_ram #(
    .WIDTH(8),
    .DEPTH(at_rlc_pkg::LINE_CAP)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(length[at_rlc_pkg::ADDR_W-1:0]),
    .wdata(rx_byte),
    .re   (cmd.rd),
    .raddr(ptr[at_rlc_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  // line scan state: leading-space count, prefix match flags, space run after action prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      lead     <= '0;
      in_lead  <= 1'b1;
      f_ok     <= 1'b1;
      f_err    <= 1'b1;
      f_act    <= 1'b1;
      f_at     <= 1'b1;
      f_http   <= 1'b1;
      s2       <= '0;
      run2     <= 1'b1;
      captured <= 1'b0;
      ptr      <= '0;
      cls_reg  <= at_rlc_pkg::CLS_IGNORED;
    end else begin
      if (cmd.begin_cmd) begin
        captured <= 1'b0;
      end
      if (we) begin
        length <= length + CW'(1);
        if (lead_byte) begin
          lead <= lead + CW'(1);
        end else begin
          in_lead <= 1'b0;
          if (j < CW'(at_rlc_pkg::OK_LEN) && rx_byte != at_rlc_pkg::PFX_OK[j[0]]) begin
            f_ok <= 1'b0;
          end
          if (j < CW'(at_rlc_pkg::ERR_LEN) && rx_byte != at_rlc_pkg::PFX_ERR[j[2:0]]) begin
            f_err <= 1'b0;
          end
          if (j < CW'(at_rlc_pkg::ACT_LEN) && rx_byte != at_rlc_pkg::PFX_ACT[j[3:0]]) begin
            f_act <= 1'b0;
          end
          if (j < CW'(at_rlc_pkg::AT_LEN) && rx_byte != at_rlc_pkg::PFX_AT[j[0]]) begin
            f_at <= 1'b0;
          end
          if (j < CW'(at_rlc_pkg::HTTP_LEN) && rx_byte != at_rlc_pkg::PFX_HTTP[j[2:0]]) begin
            f_http <= 1'b0;
          end
          if (j >= CW'(at_rlc_pkg::ACT_LEN)) begin
            if (run2 && is_space) begin
              s2 <= s2 + CW'(1);
            end else begin
              run2 <= 1'b0;
            end
          end
        end
      end
      if (cmd.classify) begin
        captured <= cap_next;
        cls_reg  <= cls;
        ptr      <= start;
      end
      if (cmd.ld_byte) begin
        ptr <= ptr + CW'(1);
      end
      // line is done once a single result is loaded or the final byte goes out
      if ((cmd.classify && !emit) || (cmd.ld_byte && stat.at_end)) begin
        length  <= '0;
        lead    <= '0;
        in_lead <= 1'b1;
        f_ok    <= 1'b1;
        f_err   <= 1'b1;
        f_act   <= 1'b1;
        f_at    <= 1'b1;
        f_http  <= 1'b1;
        s2      <= '0;
        run2    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.classify && !emit) || cmd.ld_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify && !emit) begin
      line_class   <= cls;
      payload_byte <= 8'd0;
      has_byte     <= 1'b0;
      last         <= 1'b1;
    end else if (cmd.ld_byte) begin
      line_class   <= cls_reg;
      payload_byte <= rdata;
      has_byte     <= 1'b1;
      last         <= stat.at_end;
    end
  end

endmodule

>>> src/at_rlc_ctrl.sv
module at_rlc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 command,
  input  at_rlc_pkg::dp_stat_t stat,
  output logic                 in_stall,
  output at_rlc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_RD,
    ST_LD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command) begin
            cmd.begin_cmd = 1'b1;
          end else if (stat.is_cr) begin
            state_next = ST_CLASS;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_CLASS: begin
        if (stat.emit) begin
          cmd.classify = 1'b1;
          state_next   = ST_RD;
        end else if (stat.out_free) begin
          cmd.classify = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (stat.out_free) begin
          cmd.ld_byte = 1'b1;
          state_next  = stat.at_end ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/at_rlc_checker.sv
`include "at_response_line_classifier_defines.svh"

module at_rlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       command,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] line_class,
  input logic [7:0] payload_byte,
  input logic       has_byte,
  input logic       last
);

  `AT_RLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(line_class) && $stable(payload_byte) && $stable(has_byte) && $stable(last), "stalled result changed")

  `AT_RLC_ASSERT_NOW(a_bare_is_last, out_valid && !has_byte, last && payload_byte == 8'd0, "result without byte must end the line")

  `AT_RLC_ASSERT_NOW(a_byte_class, out_valid && has_byte, line_class == at_rlc_pkg::CLS_HTTP || line_class == at_rlc_pkg::CLS_TEXT, "payload byte on a class without payload")

  `AT_RLC_ASSERT_NEXT(a_cr_stalls, in_valid && !in_stall && !command && rx_byte == at_rlc_pkg::CODE_CR, in_stall, "input not held after line end")

endmodule

bind at_response_line_classifier at_rlc_checker u_chk (.*);
